[rtl/sau_pkg.sv]
// ----------------------------------------------------------------------------
// sau_pkg
// Shared types, codes and the microprogram of the stack arithmetic unit.
// ----------------------------------------------------------------------------
package sau_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PIDX_W   = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 11;
  localparam int unsigned UPC_W    = 4;

  typedef enum logic [FUNC_W-1:0] {
    F_PUSH   = 3'd0,
    F_POP    = 3'd1,
    F_ADD    = 3'd2,
    F_SUB    = 3'd3,
    F_MUL    = 3'd4,
    F_DIV    = 3'd5,
    F_PEEK_T = 3'd6,
    F_PEEK_B = 3'd7
  } sau_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FEW     = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_RANGE   = 3'd4,
    ST_FULL    = 3'd5
  } sau_status_e;

  // memory read address source
  typedef enum logic [2:0] {
    RD_NONE,
    RD_TOP,
    RD_NEXT,
    RD_PEEK_T,
    RD_PEEK_B
  } sau_rd_e;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_RIGHT,
    LD_LEFT
  } sau_ld_e;

  typedef enum logic [1:0] {
    C_HOLD,
    C_INC,
    C_DEC,
    C_DEC2
  } sau_cnt_e;

  typedef enum logic [1:0] {
    R_ZERO,
    R_MEM,
    R_ADDSUB,
    R_ALU
  } sau_res_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_SIMPLE,
    J_DIVZ,
    J_BUSY
  } sau_jmp_e;

  typedef struct packed {
    sau_rd_e          rd;
    sau_ld_e          ld;
    logic             alu_go;
    sau_cnt_e         cnt;
    logic             wr;
    logic             wr_push;
    sau_res_e         res;
    logic             divz;
    sau_jmp_e         jmp;
    logic [UPC_W-1:0] tgt;
    logic             done;
  } sau_ucw_t;

  // jump conditions seen by the sequencer
  typedef struct packed {
    logic simple;
    logic divz;
    logic alu_busy;
  } sau_cond_t;

  // entry points
  localparam logic [UPC_W-1:0] UA_PUSH    = 4'd0;
  localparam logic [UPC_W-1:0] UA_POP     = 4'd1;
  localparam logic [UPC_W-1:0] UA_ARITH   = 4'd3;
  localparam logic [UPC_W-1:0] UA_WAIT    = 4'd8;
  localparam logic [UPC_W-1:0] UA_ADDSUB  = 4'd10;
  localparam logic [UPC_W-1:0] UA_DIVZ    = 4'd11;
  localparam logic [UPC_W-1:0] UA_PEEK_T  = 4'd12;
  localparam logic [UPC_W-1:0] UA_PEEK_FIN = 4'd13;
  localparam logic [UPC_W-1:0] UA_PEEK_B  = 4'd14;
  localparam logic [UPC_W-1:0] UA_ERR     = 4'd15;

  localparam sau_ucw_t UCW_NOP = '{
    rd: RD_NONE, ld: LD_NONE, alu_go: 1'b0, cnt: C_HOLD, wr: 1'b0,
    wr_push: 1'b0, res: R_ZERO, divz: 1'b0, jmp: J_NEXT, tgt: '0, done: 1'b0
  };

  function automatic sau_ucw_t ucode(logic [UPC_W-1:0] pc);
    sau_ucw_t w;
    w = UCW_NOP;
    unique case (pc)
      4'd0: begin  // push
        w.wr = 1'b1; w.wr_push = 1'b1; w.cnt = C_INC; w.done = 1'b1;
      end
      4'd1: w.rd = RD_TOP;
      4'd2: begin  // pop
        w.cnt = C_DEC; w.res = R_MEM; w.done = 1'b1;
      end
      4'd3: w.rd = RD_TOP;
      4'd4: begin
        w.rd = RD_NEXT; w.ld = LD_RIGHT;
      end
      4'd5: begin
        w.ld = LD_LEFT; w.cnt = C_DEC2; w.jmp = J_SIMPLE; w.tgt = UA_ADDSUB;
      end
      4'd6: begin
        w.jmp = J_DIVZ; w.tgt = UA_DIVZ;
      end
      4'd7: w.alu_go = 1'b1;
      4'd8: begin
        w.jmp = J_BUSY; w.tgt = UA_WAIT;
      end
      4'd9: begin  // mul / div result
        w.res = R_ALU; w.wr = 1'b1; w.cnt = C_INC; w.done = 1'b1;
      end
      4'd10: begin
        w.res = R_ADDSUB; w.wr = 1'b1; w.cnt = C_INC; w.done = 1'b1;
      end
      4'd11: begin
        w.divz = 1'b1; w.done = 1'b1;
      end
      4'd12: w.rd = RD_PEEK_T;
      4'd13: begin
        w.res = R_MEM; w.done = 1'b1;
      end
      4'd14: begin
        w.rd = RD_PEEK_B; w.jmp = J_ALWAYS; w.tgt = UA_PEEK_FIN;
      end
      4'd15: w.done = 1'b1;
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

endpackage

[rtl/sau_if.sv]
// ----------------------------------------------------------------------------
// sau_cmd_if / sau_rsp_if
// Valid/ready channels for commands and results of the stack unit.
// ----------------------------------------------------------------------------
interface sau_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [sau_pkg::FUNC_W-1:0]          func;
  logic signed [sau_pkg::DATA_W-1:0]   push_value;
  logic [sau_pkg::PIDX_W-1:0]          peek_index;

  modport source (output valid, func, push_value, peek_index, input ready);
  modport sink   (input valid, func, push_value, peek_index, output ready);
endinterface

interface sau_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [sau_pkg::DATA_W-1:0]   result_value;
  logic [sau_pkg::STATUS_W-1:0]        status;
  logic [sau_pkg::DEPTH_W-1:0]         stack_depth;

  modport source (output valid, result_value, status, stack_depth, input ready);
  modport sink   (input valid, result_value, status, stack_depth, output ready);
endinterface

[rtl/stack_arithmetic_unit.sv]
// Push and rejected requests finish in their first microcode step; pop and peek
// read the memory first, add and subtract read both operands, and divide by zero
// stops after the operand reads. Multiply and divide add 32 radix-2 steps of the
// shared mul/div unit plus a fixup. A new request is taken only once the last has
// finished, while its result may still wait in the output register.
// Reset: stack count and control clear at once; stack contents are not cleared.
// ----------------------------------------------------------------------------
// stack_arithmetic_unit
// Operand stack in a single-port-write memory with a microcoded datapath.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit #(
  parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  sau_cmd_if.sink   cmd_i,
  sau_rsp_if.source rsp_o
);

  localparam int unsigned W    = sau_pkg::DATA_W;
  localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CMPW = (CW > sau_pkg::PIDX_W) ? CW : sau_pkg::PIDX_W;
  localparam int unsigned EXTW = (CW > sau_pkg::DEPTH_W) ? CW : sau_pkg::DEPTH_W;

  logic [W-1:0] mem [STACK_DEPTH];

  logic [CW-1:0]              cnt_q, cnt_d;
  sau_pkg::sau_func_e         func_q;
  logic [W-1:0]               push_q;
  logic [sau_pkg::PIDX_W-1:0] idx_q;
  sau_pkg::sau_status_e       status_q, err_code;
  logic [W-1:0]               left_q, right_q;
  logic [W-1:0]               rd_q;

  logic                       out_valid_q;
  logic [W-1:0]               out_value_q;
  logic [sau_pkg::STATUS_W-1:0] out_status_q;
  logic [sau_pkg::DEPTH_W-1:0]  out_depth_q;

  logic                       start;
  logic                       busy;
  logic                       step;
  sau_pkg::sau_ucw_t          ucw;
  sau_pkg::sau_cond_t         cond;
  logic                       alu_busy;
  logic [W-1:0]               alu_res;
  logic [W-1:0]               addsub;
  logic [W-1:0]               res;
  logic [CMPW-1:0]            cnt_ext, idx_ext, raddr_w;
  logic [EXTW-1:0]            depth_ext;
  logic                       out_stall;

  assign start = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = !busy;

  // error screening at dispatch
  assign cnt_ext = CMPW'(cnt_q);
  always_comb begin
    err_code = sau_pkg::ST_OK;
    unique case (sau_pkg::sau_func_e'(cmd_i.func)) inside
      sau_pkg::F_PUSH: begin
        if (cnt_q >= CW'(STACK_DEPTH)) err_code = sau_pkg::ST_FULL;
      end
      sau_pkg::F_POP: begin
        if (cnt_q == '0) err_code = sau_pkg::ST_EMPTY;
      end
      sau_pkg::F_PEEK_T, sau_pkg::F_PEEK_B: begin
        if (CMPW'(cmd_i.peek_index) >= cnt_ext) err_code = sau_pkg::ST_RANGE;
      end
      default: begin
        if (cnt_q < CW'(2)) err_code = sau_pkg::ST_FEW;
      end
    endcase
  end

  assign out_stall = out_valid_q && !rsp_o.ready;

  assign cond.simple   = (func_q == sau_pkg::F_ADD) || (func_q == sau_pkg::F_SUB);
  assign cond.divz     = (func_q == sau_pkg::F_DIV) && (right_q == '0);
  assign cond.alu_busy = alu_busy;

  sau_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .func_i     (cmd_i.func),
    .err_i      (err_code != sau_pkg::ST_OK),
    .cond_i     (cond),
    .out_stall_i(out_stall),
    .ucw_o      (ucw),
    .busy_o     (busy),
    .step_o     (step)
  );

  sau_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (step && ucw.alu_go),
    .is_div_i(func_q == sau_pkg::F_DIV),
    .left_i  (left_q),
    .right_i (right_q),
    .busy_o  (alu_busy),
    .result_o(alu_res)
  );

  // read address from the current control word
  assign idx_ext = CMPW'(idx_q);
  always_comb begin
    unique case (ucw.rd)
      sau_pkg::RD_NEXT:   raddr_w = cnt_ext - CMPW'(2);
      sau_pkg::RD_PEEK_T: raddr_w = cnt_ext - CMPW'(1) - idx_ext;
      sau_pkg::RD_PEEK_B: raddr_w = idx_ext;
      default:            raddr_w = cnt_ext - CMPW'(1);
    endcase
  end

  assign addsub = (func_q == sau_pkg::F_SUB) ? (left_q - right_q) : (left_q + right_q);

  always_comb begin
    case (ucw.res)
      sau_pkg::R_MEM:    res = rd_q;
      sau_pkg::R_ADDSUB: res = addsub;
      sau_pkg::R_ALU:    res = alu_res;
      default:           res = '0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (step) begin
      case (ucw.cnt)
        sau_pkg::C_INC:  cnt_d = cnt_q + CW'(1);
        sau_pkg::C_DEC:  cnt_d = cnt_q - CW'(1);
        sau_pkg::C_DEC2: cnt_d = cnt_q - CW'(2);
        default:         cnt_d = cnt_q;
      endcase
    end
  end

  assign depth_ext = EXTW'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (step && ucw.wr) begin
      mem[cnt_q[AW-1:0]] <= ucw.wr_push ? push_q : res;
    end
    if (step && (ucw.rd != sau_pkg::RD_NONE)) begin
      rd_q <= mem[raddr_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (step && ucw.done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      func_q   <= sau_pkg::sau_func_e'(cmd_i.func);
      push_q   <= cmd_i.push_value;
      idx_q    <= cmd_i.peek_index;
      status_q <= err_code;
    end
    if (step && (ucw.ld == sau_pkg::LD_RIGHT)) right_q <= rd_q;
    if (step && (ucw.ld == sau_pkg::LD_LEFT))  left_q  <= rd_q;
    if (step && ucw.done) begin
      out_value_q  <= res;
      out_status_q <= ucw.divz ? sau_pkg::ST_DIVZERO : status_q;
      out_depth_q  <= depth_ext[sau_pkg::DEPTH_W-1:0];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.stack_depth  = out_depth_q;

endmodule

[rtl/sau_muldiv.sv]
// ----------------------------------------------------------------------------
// sau_muldiv
// Radix-2 multiplier and floor divider, one bit per cycle plus a fixup step.
// ----------------------------------------------------------------------------
module sau_muldiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic                        is_div_i,
  input  logic [sau_pkg::DATA_W-1:0]  left_i,
  input  logic [sau_pkg::DATA_W-1:0]  right_i,
  output logic                        busy_o,
  output logic [sau_pkg::DATA_W-1:0]  result_o
);

  localparam int unsigned W  = sau_pkg::DATA_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          fix_q, fix_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  q_q, q_d;
  logic [W-1:0]  m_q, m_d;
  logic          neg_q, neg_d;
  logic          div_q, div_d;
  logic [W-1:0]  res_q, res_d;

  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          ge;

  assign sh   = {acc_q, q_q[W-1]};
  assign diff = sh - {1'b0, m_q};
  assign ge   = (sh >= {1'b0, m_q});

  always_comb begin
    busy_d = busy_q;
    fix_d  = fix_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    q_d    = q_q;
    m_d    = m_q;
    neg_d  = neg_q;
    div_d  = div_q;
    res_d  = res_q;
    if (go_i) begin
      busy_d = 1'b1;
      fix_d  = 1'b0;
      cnt_d  = '0;
      acc_d  = '0;
      div_d  = is_div_i;
      neg_d  = left_i[W-1] ^ right_i[W-1];
      if (is_div_i) begin
        q_d = left_i[W-1]  ? (W'(0) - left_i)  : left_i;
        m_d = right_i[W-1] ? (W'(0) - right_i) : right_i;
      end else begin
        q_d = right_i;
        m_d = left_i;
      end
    end else if (busy_q && fix_q) begin
      busy_d = 1'b0;
      fix_d  = 1'b0;
      if (!div_q) begin
        res_d = acc_q;
      end else if (neg_q) begin
        // floor: step down when inexact with mixed signs
        res_d = (W'(0) - q_q) - W'(acc_q != '0);
      end else begin
        res_d = q_q;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        fix_d = 1'b1;
      end
      if (div_q) begin
        acc_d = ge ? diff[W-1:0] : sh[W-1:0];
        q_d   = {q_q[W-2:0], ge};
      end else begin
        acc_d = q_q[0] ? (acc_q + m_q) : acc_q;
        m_d   = {m_q[W-2:0], 1'b0};
        q_d   = {1'b0, q_q[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fix_q  <= fix_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    q_q   <= q_d;
    m_q   <= m_d;
    neg_q <= neg_d;
    div_q <= div_d;
    res_q <= res_d;
  end

  assign busy_o   = busy_q;
  assign result_o = res_q;

endmodule

[rtl/sau_useq.sv]
// ----------------------------------------------------------------------------
// sau_useq
// Microprogram sequencer: step counter, dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module sau_useq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sau_pkg::FUNC_W-1:0]    func_i,
  input  logic                          err_i,
  input  sau_pkg::sau_cond_t            cond_i,
  input  logic                          out_stall_i,
  output sau_pkg::sau_ucw_t             ucw_o,
  output logic                          busy_o,
  output logic                          step_o
);

  localparam int unsigned UW = sau_pkg::UPC_W;

  logic [UW-1:0]     pc_q, pc_d;
  logic              busy_q, busy_d;
  logic [UW-1:0]     entry;
  logic              taken;
  sau_pkg::sau_ucw_t ucw;

  assign ucw = sau_pkg::ucode(pc_q);

  always_comb begin
    if (err_i) begin
      entry = sau_pkg::UA_ERR;
    end else begin
      unique case (sau_pkg::sau_func_e'(func_i))
        sau_pkg::F_PUSH:   entry = sau_pkg::UA_PUSH;
        sau_pkg::F_POP:    entry = sau_pkg::UA_POP;
        sau_pkg::F_PEEK_T: entry = sau_pkg::UA_PEEK_T;
        sau_pkg::F_PEEK_B: entry = sau_pkg::UA_PEEK_B;
        default:           entry = sau_pkg::UA_ARITH;
      endcase
    end
  end

  always_comb begin
    unique case (ucw.jmp)
      sau_pkg::J_ALWAYS: taken = 1'b1;
      sau_pkg::J_SIMPLE: taken = cond_i.simple;
      sau_pkg::J_DIVZ:   taken = cond_i.divz;
      sau_pkg::J_BUSY:   taken = cond_i.alu_busy;
      default:           taken = 1'b0;
    endcase
  end

  // the final step holds while the output register is still occupied
  assign step_o = busy_q && !(ucw.done && out_stall_i);

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = entry;
    end else if (step_o) begin
      if (ucw.done) begin
        busy_d = 1'b0;
      end else begin
        pc_d = taken ? ucw.tgt : (pc_q + UW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign ucw_o  = ucw;
  assign busy_o = busy_q;

endmodule

[rtl/sau_checker.sv]
// ----------------------------------------------------------------------------
// sau_checker
// Port-level assertions for the stack arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module sau_checker #(
  parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [sau_pkg::DATA_W-1:0]    rsp_value_i,
  input logic [sau_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [sau_pkg::DEPTH_W-1:0]   rsp_depth_i
);

  localparam int unsigned EXTW = ($clog2(STACK_DEPTH + 1) > sau_pkg::DEPTH_W) ?
                                 $clog2(STACK_DEPTH + 1) : sau_pkg::DEPTH_W;
  localparam logic [EXTW-1:0] FULL_EXT = EXTW'(STACK_DEPTH);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_value_i) && $stable(rsp_status_i)
      && $stable(rsp_depth_i))
    else $error("stalled response changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != sau_pkg::ST_OK) |-> rsp_value_i == '0)
    else $error("error response carries a nonzero value");

  a_empty_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == sau_pkg::ST_EMPTY) |-> rsp_depth_i == '0)
    else $error("empty status with nonzero depth");

  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == sau_pkg::ST_FULL) |->
      rsp_depth_i == FULL_EXT[sau_pkg::DEPTH_W-1:0])
    else $error("full status with depth other than capacity");

endmodule

bind stack_arithmetic_unit sau_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.result_value),
  .rsp_status_i(rsp_o.status),
  .rsp_depth_i (rsp_o.stack_depth)
);

[bench/tb_stack_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// tb_stack_arithmetic_unit
// Self-checking bench for the stack arithmetic unit. A short table of
// requests walks the empty, too-few, range and divide corner cases first. Random
// postfix-style traffic follows, including one fill to capacity.
// Every accepted request is run through a behavioral stack model. Each result
// is compared field by field, in order, with the model's answer or the typed-in one.
// ----------------------------------------------------------------------------
module tb_stack_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STK_DEPTH   = sau_pkg::STACK_DEPTH_DEF;
  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 60;   // longer than a mul/div round trip

  localparam logic [sau_pkg::DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [sau_pkg::DATA_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [sau_pkg::DATA_W-1:0] JUNK    = 32'hA5C3_5A3C;

  typedef struct packed {
    logic [sau_pkg::DATA_W-1:0]  value;
    sau_pkg::sau_status_e        status;
    logic [sau_pkg::DEPTH_W-1:0] depth;
  } stack_rsp_t;

  typedef struct packed {
    sau_pkg::sau_func_e          fn;
    logic [sau_pkg::DATA_W-1:0]  pv;
    logic [sau_pkg::PIDX_W-1:0]  ix;
    logic                        typed;   // use the typed-in answer below
    stack_rsp_t                  want;
  } stack_req_t;

  localparam stack_rsp_t NO_RSP = '{'0, sau_pkg::ST_OK, '0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sau_cmd_if cmd_if ();
  sau_rsp_if rsp_if ();

  stack_arithmetic_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // model state
  logic [sau_pkg::DATA_W-1:0] stk_mem [STK_DEPTH];
  int unsigned                stk_cnt = 0;

  stack_rsp_t  pending_rsp_q [$];
  stack_req_t  dir_tab [$];
  int unsigned n_fail        = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned cmd_gap_pct   = 28;
  int unsigned rsp_stall_pct = 75;

  function automatic stack_rsp_t run_stack_cmd(sau_pkg::sau_func_e fn,
                                               logic [sau_pkg::DATA_W-1:0] pv,
                                               logic [sau_pkg::PIDX_W-1:0] ix);
    stack_rsp_t                 r;
    logic [sau_pkg::DATA_W-1:0] lhs;
    logic [sau_pkg::DATA_W-1:0] rhs;
    longint                     sl;
    longint                     sr;
    longint                     q;
    r = NO_RSP;
    case (fn) inside
      sau_pkg::F_PUSH: begin
        if (stk_cnt < STK_DEPTH) begin
          stk_mem[stk_cnt] = pv;
          stk_cnt++;
        end else begin
          r.status = sau_pkg::ST_FULL;
        end
      end
      sau_pkg::F_POP: begin
        if (stk_cnt > 0) begin
          stk_cnt--;
          r.value = stk_mem[stk_cnt];
        end else begin
          r.status = sau_pkg::ST_EMPTY;
        end
      end
      sau_pkg::F_ADD, sau_pkg::F_SUB, sau_pkg::F_MUL, sau_pkg::F_DIV: begin
        if (stk_cnt < 2) begin
          r.status = sau_pkg::ST_FEW;
        end else begin
          // top is the right operand, the one below it the left
          rhs = stk_mem[stk_cnt - 1];
          lhs = stk_mem[stk_cnt - 2];
          stk_cnt -= 2;
          case (fn)
            sau_pkg::F_ADD: r.value = lhs + rhs;
            sau_pkg::F_SUB: r.value = lhs - rhs;
            sau_pkg::F_MUL: r.value = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                r.status = sau_pkg::ST_DIVZERO;
              end else begin
                // floor division; min / -1 wraps back to min in the low word
                sl = longint'(signed'(lhs));
                sr = longint'(signed'(rhs));
                q  = sl / sr;
                if ((sl % sr != 0) && ((sl < 0) != (sr < 0))) q = q - 1;
                r.value = q[sau_pkg::DATA_W-1:0];
              end
            end
          endcase
          if (r.status == sau_pkg::ST_OK) begin
            stk_mem[stk_cnt] = r.value;
            stk_cnt++;
          end
        end
      end
      default: begin
        if (ix < stk_cnt) begin
          r.value = (fn == sau_pkg::F_PEEK_T) ? stk_mem[stk_cnt - ix - 1] : stk_mem[ix];
        end else begin
          r.status = sau_pkg::ST_RANGE;
        end
      end
    endcase
    r.depth = sau_pkg::DEPTH_W'(stk_cnt);
    return r;
  endfunction

  function automatic logic [sau_pkg::DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom();
    if (sel < 70) return sau_pkg::DATA_W'(int'($urandom_range(20)) - 10);
    if (sel < 85) begin
      case ($urandom_range(4))
        0: return '0;
        1: return 32'd1;
        2: return '1;
        3: return INT_MIN;
        default: return INT_MAX;
      endcase
    end
    return sau_pkg::DATA_W'($urandom_range(1000));
  endfunction

  task automatic issue_req(stack_req_t c);
    stack_rsp_t pred;
    while ($urandom_range(99) < cmd_gap_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.func       <= c.fn;
    cmd_if.push_value <= c.pv;
    cmd_if.peek_index <= c.ix;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pred = run_stack_cmd(c.fn, c.pv, c.ix);
    pending_rsp_q.push_back(c.typed ? c.want : pred);
  endtask

  task automatic issue_random(int unsigned push_pct);
    stack_req_t c;
    c.fn = ($urandom_range(99) < push_pct) ? sau_pkg::F_PUSH
                                           : sau_pkg::sau_func_e'($urandom_range(1, 7));
    c.pv = pick_value();
    // mostly valid peek offsets, the rest anywhere in the field
    if (stk_cnt != 0 && $urandom_range(3) != 0) begin
      c.ix = sau_pkg::PIDX_W'($urandom_range(stk_cnt - 1));
    end else begin
      c.ix = sau_pkg::PIDX_W'($urandom());
    end
    c.typed = 1'b0;
    c.want  = NO_RSP;
    issue_req(c);
  endtask

  // keep the stack shallow but populated so arithmetic mostly succeeds
  task automatic run_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      issue_random(stk_cnt < 6 ? 55 : (stk_cnt > 48 ? 15 : 35));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    stack_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_if.result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, rsp_if.result_value);
          n_fail++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          n_fail++;
        end
        if (rsp_if.stack_depth !== want.depth) begin
          $error("stack_depth: expected %0d, got %0d", want.depth, rsp_if.stack_depth);
          n_fail++;
        end
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  initial begin
    cmd_if.valid      = 1'b0;
    cmd_if.func       = sau_pkg::F_PUSH;
    cmd_if.push_value = '0;
    cmd_if.peek_index = '0;

    // corner cases; answers typed in where they are obvious
    dir_tab.push_back('{sau_pkg::F_POP,    JUNK,    10'd0,   1'b1,
                        '{'0, sau_pkg::ST_EMPTY, 11'd0}});
    dir_tab.push_back('{sau_pkg::F_ADD,    JUNK,    10'd0,   1'b1,
                        '{'0, sau_pkg::ST_FEW, 11'd0}});
    dir_tab.push_back('{sau_pkg::F_PEEK_T, JUNK,    10'd0,   1'b1,
                        '{'0, sau_pkg::ST_RANGE, 11'd0}});
    dir_tab.push_back('{sau_pkg::F_PEEK_B, JUNK,    10'h3FF, 1'b1,
                        '{'0, sau_pkg::ST_RANGE, 11'd0}});
    dir_tab.push_back('{sau_pkg::F_PUSH,   INT_MAX, 10'h3FF, 1'b1,
                        '{'0, sau_pkg::ST_OK, 11'd1}});
    dir_tab.push_back('{sau_pkg::F_SUB,    JUNK,    10'd0,   1'b1,
                        '{'0, sau_pkg::ST_FEW, 11'd1}});
    dir_tab.push_back('{sau_pkg::F_PUSH,   INT_MIN, 10'd0,   1'b1,
                        '{'0, sau_pkg::ST_OK, 11'd2}});
    dir_tab.push_back('{sau_pkg::F_PEEK_T, JUNK,    10'd0,   1'b1,
                        '{INT_MIN, sau_pkg::ST_OK, 11'd2}});
    dir_tab.push_back('{sau_pkg::F_PEEK_B, JUNK,    10'd0,   1'b1,
                        '{INT_MAX, sau_pkg::ST_OK, 11'd2}});
    dir_tab.push_back('{sau_pkg::F_PEEK_T, JUNK,    10'd2,   1'b1,
                        '{'0, sau_pkg::ST_RANGE, 11'd2}});
    dir_tab.push_back('{sau_pkg::F_ADD,    JUNK,    10'd0,   1'b1,
                        '{'1, sau_pkg::ST_OK, 11'd1}});
    dir_tab.push_back('{sau_pkg::F_PUSH,   '0,      10'd0,   1'b1,
                        '{'0, sau_pkg::ST_OK, 11'd2}});
    dir_tab.push_back('{sau_pkg::F_DIV,    JUNK,    10'd0,   1'b1,
                        '{'0, sau_pkg::ST_DIVZERO, 11'd0}});
    dir_tab.push_back('{sau_pkg::F_PUSH,   INT_MIN, 10'd0,   1'b1,
                        '{'0, sau_pkg::ST_OK, 11'd1}});
    dir_tab.push_back('{sau_pkg::F_PUSH,   '1,      10'd0,   1'b1,
                        '{'0, sau_pkg::ST_OK, 11'd2}});
    // most negative over minus one wraps
    dir_tab.push_back('{sau_pkg::F_DIV,    JUNK,    10'd0,   1'b1,
                        '{INT_MIN, sau_pkg::ST_OK, 11'd1}});
    dir_tab.push_back('{sau_pkg::F_PUSH,   32'd7,   10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_MUL,    JUNK,    10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_PUSH,   -32'sd7, 10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_PUSH,   32'd2,   10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_DIV,    JUNK,    10'd0,   1'b0, NO_RSP});
    // exact quotient with operands of differing sign
    dir_tab.push_back('{sau_pkg::F_PUSH,   32'd6,   10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_PUSH,   -32'sd3, 10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_DIV,    JUNK,    10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_SUB,    JUNK,    10'd0,   1'b0, NO_RSP});
    dir_tab.push_back('{sau_pkg::F_POP,    JUNK,    10'd0,   1'b0, NO_RSP});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) issue_req(dir_tab[i]);
    run_random(450);

    cmd_gap_pct   = 75;
    rsp_stall_pct = 28;
    run_random(450);

    cmd_gap_pct   = 0;
    rsp_stall_pct = 0;
    while (stk_cnt < STK_DEPTH) issue_random(100);
    issue_req('{sau_pkg::F_PEEK_T, JUNK, 10'h3FF, 1'b0, NO_RSP});
    issue_req('{sau_pkg::F_PEEK_B, JUNK, 10'h3FF, 1'b0, NO_RSP});
    // hover at capacity so pushes bounce off a full stack
    for (int i = 0; i < 12; i++) issue_random(stk_cnt == STK_DEPTH ? 30 : 70);
    run_random(100);

    cmd_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sau_pkg.sv
rtl/sau_if.sv
rtl/sau_muldiv.sv
rtl/sau_useq.sv
rtl/stack_arithmetic_unit.sv
rtl/sau_checker.sv
bench/tb_stack_arithmetic_unit.sv
